/* rtl/smcrg_pkg.sv */
package smcrg_pkg;

    localparam int BLOCK_BYTES       = 8;
    localparam int MAX_REQUEST_BYTES = 256;
    localparam int WORD_W            = 64;
    localparam int HALF_W            = 32;
    localparam int REQ_W             = 9;
    localparam int LEN_W             = 4;

    localparam logic [WORD_W-1:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] MIX_C2 = 64'h94d049bb133111eb;
    localparam int MIX_S1 = 30;
    localparam int MIX_S2 = 27;
    localparam int MIX_S3 = 31;

    localparam logic OP_FOLD     = 1'b0;
    localparam logic OP_GENERATE = 1'b1;

    typedef struct packed {
        logic load_fold;
        logic load_block;
        logic init_req;
        logic mul_phase_a;
        logic mul_phase_b;
        logic mul_phase_c;
        logic mul_second;
        logic fold_commit;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic last_chunk;
    } t_status;

    function automatic logic [WORD_W-1:0] byte_mask(input logic [LEN_W-1:0] nbytes);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            if (LEN_W'(i) < nbytes) begin
                m[i*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

/* rtl/splitmix_counter_random_generator_top.sv */
// Splitmix64 counter-mode generator. A transaction is taken when start is high
// and busy is low. A fold transaction keeps busy high until the seed is updated.
// A generate transaction for N bytes (capped at 256) yields ceil(N/8) blocks,
// computed one after another while busy stays high; each block is registered
// and shown for a single cycle with o_strobe. The block time is set by one
// shared 32x32 multiplier that needs three passes per 64-bit product and two
// products per block. Results cannot be held off: capture every o_strobe cycle.
// Folds and zero length requests produce no result.
module splitmix_counter_random_generator_top
    import smcrg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_opcode,
    input  logic [WORD_W-1:0] i_entropy_word,
    input  logic [LEN_W-1:0]  i_entropy_length,
    input  logic [REQ_W-1:0]  i_request_length,
    output logic [WORD_W-1:0] o_random_bytes,
    output logic [LEN_W-1:0]  o_valid_bytes,
    output logic              o_last_block,
    output logic              o_strobe
);

    t_cmd    cmd;
    t_status status;

    smcrg_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_entropy_length (i_entropy_length),
        .i_request_length (i_request_length),
        .i_status         (status),
        .o_cmd            (cmd)
    );

    smcrg_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_entropy_word   (i_entropy_word),
        .i_entropy_length (i_entropy_length),
        .i_request_length (i_request_length),
        .o_random_bytes   (o_random_bytes),
        .o_valid_bytes    (o_valid_bytes),
        .o_last_block     (o_last_block),
        .o_strobe         (o_strobe)
    );

    a_valid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_valid_bytes != '0 && o_valid_bytes <= LEN_W'(BLOCK_BYTES)))
        else $error("valid byte count out of range");

    a_full_unless_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_block) |-> (o_valid_bytes == LEN_W'(BLOCK_BYTES)))
        else $error("partial block before end of request");

    a_tail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_random_bytes & ~byte_mask(o_valid_bytes)) == '0))
        else $error("unused bytes not cleared");

    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_block) |-> busy)
        else $error("request ended before final block");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("blocks emitted back to back");

endmodule

/* rtl/smcrg_ctrl.sv */
module smcrg_ctrl
    import smcrg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_opcode,
    input  logic [LEN_W-1:0] i_entropy_length,
    input  logic [REQ_W-1:0] i_request_length,
    input  t_status          i_status,
    output t_cmd             o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_M1A  = 8'b0000_0010,
        S_M1B  = 8'b0000_0100,
        S_M1C  = 8'b0000_1000,
        S_M2A  = 8'b0001_0000,
        S_M2B  = 8'b0010_0000,
        S_M2C  = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_gen_mode, n_gen_mode;

    always_comb begin
        n_state    = r_state;
        n_gen_mode = r_gen_mode;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_opcode == OP_FOLD && i_entropy_length != '0) begin
                        o_cmd.load_fold = 1'b1;
                        n_gen_mode      = 1'b0;
                        n_state         = S_M1A;
                    end else if (i_opcode == OP_GENERATE && i_request_length != '0) begin
                        o_cmd.load_block = 1'b1;
                        o_cmd.init_req   = 1'b1;
                        n_gen_mode       = 1'b1;
                        n_state          = S_M1A;
                    end
                end
            end
            S_M1A: begin
                o_cmd.mul_phase_a = 1'b1;
                n_state           = S_M1B;
            end
            S_M1B: begin
                o_cmd.mul_phase_b = 1'b1;
                n_state           = S_M1C;
            end
            S_M1C: begin
                o_cmd.mul_phase_c = 1'b1;
                n_state           = S_M2A;
            end
            S_M2A: begin
                o_cmd.mul_phase_a = 1'b1;
                o_cmd.mul_second  = 1'b1;
                n_state           = S_M2B;
            end
            S_M2B: begin
                o_cmd.mul_phase_b = 1'b1;
                o_cmd.mul_second  = 1'b1;
                n_state           = S_M2C;
            end
            S_M2C: begin
                o_cmd.mul_phase_c = 1'b1;
                o_cmd.mul_second  = 1'b1;
                n_state           = S_FIN;
            end
            S_FIN: begin
                if (!r_gen_mode) begin
                    o_cmd.fold_commit = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last_chunk) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.load_block = 1'b1;
                        n_state          = S_M1A;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_gen_mode <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_gen_mode <= n_gen_mode;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

/* rtl/smcrg_dp.sv */
module smcrg_dp
    import smcrg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  logic [WORD_W-1:0] i_entropy_word,
    input  logic [LEN_W-1:0]  i_entropy_length,
    input  logic [REQ_W-1:0]  i_request_length,
    output logic [WORD_W-1:0] o_random_bytes,
    output logic [LEN_W-1:0]  o_valid_bytes,
    output logic              o_last_block,
    output logic              o_strobe
);

    logic [WORD_W-1:0] r_seed, r_counter, r_x, r_acc;
    logic [REQ_W-1:0]  r_remaining;
    logic [WORD_W-1:0] r_out_bytes;
    logic [LEN_W-1:0]  r_out_valid;
    logic              r_out_last;
    logic              r_out_strobe;

    logic [WORD_W-1:0] cnt_next, fold_in, block_in, v_in, v_pre, y, fin;
    logic [WORD_W-1:0] mix_const;
    logic [HALF_W-1:0] m_a, m_b;
    logic [WORD_W-1:0] m_p;
    logic [LEN_W-1:0]  chunk;
    logic              last;

    assign cnt_next = r_counter + 64'd1;
    assign fold_in  = r_seed ^ (i_entropy_word & byte_mask(i_entropy_length));
    assign block_in = r_seed ^ cnt_next;
    assign v_in     = i_cmd.load_fold ? fold_in : block_in;
    assign v_pre    = v_in ^ (v_in >> MIX_S1);
    assign y        = r_acc ^ (r_acc >> MIX_S2);
    assign fin      = r_acc ^ (r_acc >> MIX_S3);

    assign last  = (r_remaining <= REQ_W'(BLOCK_BYTES));
    assign chunk = last ? r_remaining[LEN_W-1:0] : LEN_W'(BLOCK_BYTES);
    assign o_status.last_chunk = last;

    assign mix_const = i_cmd.mul_second ? MIX_C2 : MIX_C1;

    always_comb begin
        m_a = r_x[HALF_W-1:0];
        m_b = mix_const[HALF_W-1:0];
        if (i_cmd.mul_phase_a) begin
            m_a = i_cmd.mul_second ? y[HALF_W-1:0] : r_x[HALF_W-1:0];
        end else if (i_cmd.mul_phase_b) begin
            m_a = r_x[WORD_W-1:HALF_W];
        end else if (i_cmd.mul_phase_c) begin
            m_b = mix_const[WORD_W-1:HALF_W];
        end
    end

    assign m_p = WORD_W'(m_a) * WORD_W'(m_b);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_fold || i_cmd.load_block) begin
            r_x <= v_pre;
        end else if (i_cmd.mul_phase_a && i_cmd.mul_second) begin
            r_x <= y;
        end
        if (i_cmd.mul_phase_a) begin
            r_acc <= m_p;
        end else if (i_cmd.mul_phase_b || i_cmd.mul_phase_c) begin
            r_acc[WORD_W-1:HALF_W] <= r_acc[WORD_W-1:HALF_W] + m_p[HALF_W-1:0];
        end
        if (i_cmd.init_req) begin
            r_remaining <= (i_request_length > REQ_W'(MAX_REQUEST_BYTES))
                         ? REQ_W'(MAX_REQUEST_BYTES) : i_request_length;
        end else if (i_cmd.emit) begin
            r_remaining <= r_remaining - REQ_W'(chunk);
        end
        if (i_cmd.emit) begin
            r_out_bytes <= fin & byte_mask(chunk);
            r_out_valid <= chunk;
            r_out_last  <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed       <= '0;
            r_counter    <= '0;
            r_out_strobe <= 1'b0;
        end else begin
            r_out_strobe <= i_cmd.emit;
            if (i_cmd.fold_commit) begin
                r_seed    <= fin;
                r_counter <= '0;
            end else if (i_cmd.load_block) begin
                r_counter <= cnt_next;
            end
        end
    end

    assign o_random_bytes = r_out_bytes;
    assign o_valid_bytes  = r_out_valid;
    assign o_last_block   = r_out_last;
    assign o_strobe       = r_out_strobe;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import smcrg_pkg::*;

    localparam int  N_DIRECTED  = 21;
    localparam int  N_RANDOM    = 259;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  MAX_REPORTS = 10;

    typedef struct {
        logic              op;
        logic [WORD_W-1:0] word;
        logic [LEN_W-1:0]  elen;
        logic [REQ_W-1:0]  rlen;
        int                blocks;
    } t_stim_row;

    typedef struct {
        logic [WORD_W-1:0] data;
        logic [LEN_W-1:0]  nbytes;
        logic              last;
    } t_block;

    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              start            = 1'b0;
    logic              i_opcode         = OP_FOLD;
    logic [WORD_W-1:0] i_entropy_word   = '0;
    logic [LEN_W-1:0]  i_entropy_length = '0;
    logic [REQ_W-1:0]  i_request_length = '0;
    logic              busy;
    logic [WORD_W-1:0] o_random_bytes;
    logic [LEN_W-1:0]  o_valid_bytes;
    logic              o_last_block;
    logic              o_strobe;

    logic [WORD_W-1:0] seed_value    = '0;
    logic [WORD_W-1:0] block_counter = '0;
    t_block            pending_blocks[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int blocks_checked = 0;
    int folds_sent     = 0;
    int requests_sent  = 0;

    t_stim_row directed_rows [0:N_DIRECTED-1] = '{
        '{OP_GENERATE, 64'h0, 4'd0, 9'd8, 1},
        '{OP_GENERATE, 64'hffff_ffff_ffff_ffff, 4'd15, 9'd1, 1},
        '{OP_GENERATE, 64'h0, 4'd0, 9'd0, 0},
        '{OP_FOLD, 64'hffff_ffff_ffff_ffff, 4'd0, 9'd0, 0},
        '{OP_GENERATE, 64'h0, 4'd0, 9'd9, 2},
        '{OP_FOLD, 64'hffff_ffff_ffff_ffff, 4'd1, 9'h1ff, 0},
        '{OP_GENERATE, 64'h0, 4'd0, 9'd7, 1},
        '{OP_FOLD, 64'h0123_4567_89ab_cdef, 4'd8, 9'd0, 0},
        '{OP_GENERATE, 64'h0, 4'd0, 9'd16, 2},
        '{OP_FOLD, 64'hffff_ffff_ffff_ffff, 4'd15, 9'd0, 0},
        '{OP_FOLD, 64'hfedc_ba98_7654_3210, 4'd9, 9'd0, 0},
        '{OP_GENERATE, 64'h0, 4'd0, 9'd256, 32},
        '{OP_GENERATE, 64'h0, 4'd0, 9'd257, 32},
        '{OP_GENERATE, 64'hffff_ffff_ffff_ffff, 4'd8, 9'h1ff, 32},
        '{OP_FOLD, 64'h0, 4'd3, 9'd0, 0},
        '{OP_FOLD, 64'h8000_0000_0000_0001, 4'd7, 9'd0, 0},
        '{OP_GENERATE, 64'h0, 4'd0, 9'd255, 32},
        '{OP_GENERATE, 64'h0, 4'd0, 9'd15, 2},
        '{OP_GENERATE, 64'h0, 4'd0, 9'd128, 16},
        '{OP_FOLD, 64'hffff_ffff_ffff_ffff, 4'd2, 9'd256, 0},
        '{OP_GENERATE, 64'h0, 4'd0, 9'd3, 1}
    };

    splitmix_counter_random_generator_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_entropy_word   (i_entropy_word),
        .i_entropy_length (i_entropy_length),
        .i_request_length (i_request_length),
        .o_random_bytes   (o_random_bytes),
        .o_valid_bytes    (o_valid_bytes),
        .o_last_block     (o_last_block),
        .o_strobe         (o_strobe)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [WORD_W-1:0] finalize64(input logic [WORD_W-1:0] v);
        v = v ^ (v >> MIX_S1);
        v = v * MIX_C1;
        v = v ^ (v >> MIX_S2);
        v = v * MIX_C2;
        v = v ^ (v >> MIX_S3);
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] low_bytes(input int n);
        if (n >= BLOCK_BYTES) begin
            return '1;
        end
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    // advance the generator state and queue the blocks this transaction yields
    function automatic int forecast_blocks(input logic op, input logic [WORD_W-1:0] word,
                                           input logic [LEN_W-1:0] elen,
                                           input logic [REQ_W-1:0] rlen);
        int     remain;
        int     chunk;
        int     n;
        t_block blk;
        n = 0;
        if (op == OP_FOLD) begin
            if (elen == 0) begin
                return 0;
            end
            chunk = (elen > BLOCK_BYTES) ? BLOCK_BYTES : int'(elen);
            seed_value    = finalize64(seed_value ^ (word & low_bytes(chunk)));
            block_counter = '0;
            return 0;
        end
        remain = (rlen > MAX_REQUEST_BYTES) ? MAX_REQUEST_BYTES : int'(rlen);
        while (remain > 0) begin
            chunk = (remain > BLOCK_BYTES) ? BLOCK_BYTES : remain;
            block_counter = block_counter + 64'd1;
            remain = remain - chunk;
            blk.data   = finalize64(seed_value ^ block_counter) & low_bytes(chunk);
            blk.nbytes = LEN_W'(chunk);
            blk.last   = (remain == 0);
            pending_blocks.push_back(blk);
            n++;
        end
        return n;
    endfunction

    task automatic note_mismatch(input string what, input logic [WORD_W-1:0] exp_v,
                                 input logic [WORD_W-1:0] act_v);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, exp_v,
                     act_v);
        end
    endtask

    // hold the transaction until busy drops, then update the prediction
    task automatic send_transaction(input logic op, input logic [WORD_W-1:0] word,
                                    input logic [LEN_W-1:0] elen,
                                    input logic [REQ_W-1:0] rlen, input int gap,
                                    output int nblk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_opcode         <= op;
        i_entropy_word   <= word;
        i_entropy_length <= elen;
        i_request_length <= rlen;
        start            <= 1'b1;
        do @(posedge i_clk); while (busy);
        nblk = forecast_blocks(op, word, elen, rlen);
        if (op == OP_FOLD) begin
            folds_sent++;
        end else begin
            requests_sent++;
        end
    endtask

    function automatic int pick_gap(input int idx);
        if ((idx / 32) % 3 == 2) begin
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_block exp_blk;
        if (i_rst_n && o_strobe) begin
            if (pending_blocks.size() == 0) begin
                note_mismatch("unexpected block", '0, o_random_bytes);
            end else begin
                exp_blk = pending_blocks.pop_front();
                blocks_checked++;
                if (o_random_bytes !== exp_blk.data) begin
                    note_mismatch("random_bytes", exp_blk.data, o_random_bytes);
                end
                if (o_valid_bytes !== exp_blk.nbytes) begin
                    note_mismatch("valid_bytes", 64'(exp_blk.nbytes), 64'(o_valid_bytes));
                end
                if (o_last_block !== exp_blk.last) begin
                    note_mismatch("last_block", 64'(exp_blk.last), 64'(o_last_block));
                end
            end
        end
    end

    initial begin
        int                nblk;
        int                draw;
        logic              op;
        logic [WORD_W-1:0] word;
        logic [LEN_W-1:0]  elen;
        logic [REQ_W-1:0]  rlen;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            send_transaction(directed_rows[k].op, directed_rows[k].word,
                             directed_rows[k].elen, directed_rows[k].rlen,
                             $urandom_range(0, 15), nblk);
            if (nblk != directed_rows[k].blocks) begin
                note_mismatch("block count", 64'(directed_rows[k].blocks), 64'(nblk));
            end
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 2) begin
                start <= 1'b0;
                @(posedge i_clk);
                while (pending_blocks.size() != 0) @(posedge i_clk);
            end
            word = {$urandom, $urandom};
            op   = ($urandom_range(0, 99) < 35) ? OP_FOLD : OP_GENERATE;
            elen = LEN_W'($urandom_range(0, 15));
            draw = $urandom_range(0, 99);
            if (draw < 70) begin
                rlen = REQ_W'($urandom_range(0, 24));
            end else if (draw < 90) begin
                rlen = REQ_W'($urandom_range(25, 256));
            end else begin
                rlen = REQ_W'($urandom_range(257, 511));
            end
            send_transaction(op, word, elen, rlen, pick_gap(i), nblk);
        end
        start <= 1'b0;

        while (pending_blocks.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("sent %0d folds and %0d generate requests, checked %0d blocks",
                 folds_sent, requests_sent, blocks_checked);
        $display("mismatches: %0d", mismatch_count);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* splitmix_counter_random_generator_top.f */
rtl/smcrg_pkg.sv
rtl/smcrg_ctrl.sv
rtl/smcrg_dp.sv
rtl/splitmix_counter_random_generator_top.sv
dv/tb_top.sv
